/* src/bcl_pkg.sv */
// bcl_pkg: shared constants and types for the button click / long-press block.
// No dependencies; every other file of the block refers to it by scoped names.

package bcl_pkg;

	// Fixed field widths
	localparam int LEVEL_W   = 4;
	localparam int EVENT_W   = 4;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	// Defaults
	localparam int BUTTONS_DEFAULT = 4;
	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd10;
	localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd350;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

	// Per-button events for the current tick
	typedef struct packed {
		logic click;
		logic long_press;
	} btn_evt_t;

endpackage

/* src/bcl_in_if.sv */
// bcl_in_if: request channel carrying one tick of button pin levels.
// Depends on bcl_pkg for the field width.

interface bcl_in_if;
	logic                         valid;
	logic                         ready;
	logic [bcl_pkg::LEVEL_W-1:0]  button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink   (input valid, input button_levels, output ready);
endinterface

/* src/bcl_out_if.sv */
// bcl_out_if: result channel carrying the click and long-press events of one tick.
// Depends on bcl_pkg for the field widths.

interface bcl_out_if;
	logic                         valid;
	logic                         ready;
	logic [bcl_pkg::EVENT_W-1:0]  click_events;
	logic [bcl_pkg::EVENT_W-1:0]  long_events;

	modport source (output valid, output click_events, output long_events, input ready);
	modport sink   (input valid, input click_events, input long_events, output ready);
endinterface

/* src/bcl_cfg_if.sv */
// bcl_cfg_if: configuration write channel (register index and write data).
// Depends on bcl_pkg for the index and data widths.

interface bcl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bcl_pkg::CFG_IDX_W-1:0]  index;
	logic [bcl_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/button_click_long_press_top.sv */
// button_click_long_press_top: click / long-press classifier for active-low buttons.
// Depends on bcl_pkg, bcl_in_if, bcl_out_if, bcl_cfg_if and bcl_button.

// Each request on samples is one tick carrying the pin level of every button
// (0 = pressed); each tick yields exactly one result on events, in the cycle after
// it is accepted, holding a click bit per button released after a debounced
// short press and a long bit per button on the tick its hold reaches
// long_press_ticks. The block takes one tick per cycle: every button's counter
// and marks update together as a tick is accepted, and the result sits in an output register,
// so samples.ready stays high unless a result is held waiting on events.ready.
// A press shorter than debounce_ticks gives nothing; counters saturate at 65535.
// Buttons numbered 4 and above read as pressed and their events are not visible.
// Write register 0 (debounce_ticks) or 1 (long_press_ticks) through cfg only
// while the block is idle; other indexes are ignored. cfg is always ready.

module button_click_long_press_top #(
	parameter int BUTTONS = bcl_pkg::BUTTONS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	bcl_in_if.sink       samples,
	bcl_out_if.source    events,
	bcl_cfg_if.sink      cfg
);

	// Configuration registers
	logic [bcl_pkg::CNT_W-1:0] debounce_q;
	logic [bcl_pkg::CNT_W-1:0] long_press_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bcl_pkg::DEBOUNCE_RESET;
			long_press_q <= bcl_pkg::LONG_PRESS_RESET;
		end else if (cfg.valid) begin
			// drop writes to unknown indexes
			if (cfg.index == bcl_pkg::REG_DEBOUNCE) begin
				debounce_q <= cfg.data;
			end else if (cfg.index == bcl_pkg::REG_LONG_PRESS) begin
				long_press_q <= cfg.data;
			end
		end
	end

	// Handshake: accept a tick whenever the output register is free or drains now
	logic out_valid_q;
	logic accept;

	assign samples.ready = !out_valid_q || events.ready;
	assign accept        = samples.valid && samples.ready;

	// Per-button cells
	bcl_pkg::btn_evt_t evt [BUTTONS];

	for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
		logic pressed;
		if (b < bcl_pkg::LEVEL_W) begin : g_pin
			assign pressed = !samples.button_levels[b];
		end else begin : g_nopin
			// no pin in the field: reads level 0, i.e. held
			assign pressed = 1'b1;
		end

		bcl_button u_button (
			.clk              (clk),
			.arst_n           (arst_n),
			.en               (accept),
			.pressed          (pressed),
			.debounce_ticks   (debounce_q),
			.long_press_ticks (long_press_q),
			.evt              (evt[b])
		);
	end

	// Gather the visible event bits
	logic [bcl_pkg::EVENT_W-1:0] click_d, long_d;

	for (genvar i = 0; i < bcl_pkg::EVENT_W; i++) begin : g_evt
		if (i < BUTTONS) begin : g_used
			assign click_d[i] = evt[i].click;
			assign long_d[i]  = evt[i].long_press;
		end else begin : g_unused
			assign click_d[i] = 1'b0;
			assign long_d[i]  = 1'b0;
		end
	end

	// Output register
	logic [bcl_pkg::EVENT_W-1:0] click_q, long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until a new tick replaces it
	always_ff @(posedge clk) begin
		if (accept) begin
			click_q <= click_d;
			long_q  <= long_d;
		end
	end

	assign events.valid        = out_valid_q;
	assign events.click_events = click_q;
	assign events.long_events  = long_q;

	// Assertions
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> events.valid)
		else $error("accepted tick gave no result in the next cycle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!events.valid |-> samples.ready)
		else $error("input stalled while output register is empty");

	a_no_click_and_long: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid |-> ((events.click_events & events.long_events) == '0))
		else $error("button gave click and long press on the same tick");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && !events.ready) |=> (events.valid && $stable(events.long_events)))
		else $error("held result changed before it was taken");

endmodule

/* src/bcl_button.sv */
// bcl_button: hold counter and detected/down/long marks of one button.
// Depends on bcl_pkg; instantiated once per button by the top level.

module bcl_button (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        pressed,
	input  logic [bcl_pkg::CNT_W-1:0]   debounce_ticks,
	input  logic [bcl_pkg::CNT_W-1:0]   long_press_ticks,
	output bcl_pkg::btn_evt_t           evt
);

	logic [bcl_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic det_q, det_d;
	logic down_q, down_d;
	logic long_q, long_d;

	// saturate at all ones
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + bcl_pkg::CNT_W'(1);

	always_comb begin
		cnt_d          = cnt_q;
		det_d          = det_q;
		down_d         = down_q;
		long_d         = long_q;
		evt.click      = 1'b0;
		evt.long_press = 1'b0;
		if (pressed) begin
			if (!long_q) begin
				cnt_d = cnt_inc;
				det_d = 1'b1;
				if (down_q) begin
					if (cnt_inc >= long_press_ticks) begin
						long_d         = 1'b1;
						evt.long_press = 1'b1;
					end
				end else if (cnt_inc >= debounce_ticks) begin
					down_d = 1'b1;
				end
			end
		end else if (det_q) begin
			evt.click = down_q && !long_q;
			cnt_d     = '0;
			det_d     = 1'b0;
			down_d    = 1'b0;
			long_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			det_q  <= 1'b0;
			down_q <= 1'b0;
			long_q <= 1'b0;
		end else if (en) begin
			cnt_q  <= cnt_d;
			det_q  <= det_d;
			down_q <= down_d;
			long_q <= long_d;
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for button_click_long_press_top.
// Depends on bcl_pkg and the bcl_in_if, bcl_out_if and bcl_cfg_if interfaces.

module testbench;

	// Register indexes the block has no register behind
	localparam logic [bcl_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
	localparam logic [bcl_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

	// Tracks every button's hold counter and marks, and queues the events
	// each accepted tick must produce.
	class press_scoreboard;
		typedef struct packed {
			logic [bcl_pkg::EVENT_W-1:0] clicks;
			logic [bcl_pkg::EVENT_W-1:0] longs;
		} tick_events_t;

		logic [bcl_pkg::CNT_W-1:0] debounce_limit;
		logic [bcl_pkg::CNT_W-1:0] long_limit;
		logic [bcl_pkg::CNT_W-1:0] hold_ticks[bcl_pkg::LEVEL_W];
		bit               seen[bcl_pkg::LEVEL_W];
		bit               down[bcl_pkg::LEVEL_W];
		bit               flagged[bcl_pkg::LEVEL_W];
		tick_events_t     due_events[$];
		int               failures;

		function new();
			debounce_limit = bcl_pkg::DEBOUNCE_RESET;
			long_limit = bcl_pkg::LONG_PRESS_RESET;
			foreach (hold_ticks[b]) begin
				hold_ticks[b] = '0;
				seen[b] = 1'b0;
				down[b] = 1'b0;
				flagged[b] = 1'b0;
			end
			failures = 0;
		endfunction

		function void write_reg(logic [bcl_pkg::CFG_IDX_W-1:0] idx,
			logic [bcl_pkg::CFG_DAT_W-1:0] value);
			case (idx)
				bcl_pkg::REG_DEBOUNCE: begin
					debounce_limit = value;
				end
				bcl_pkg::REG_LONG_PRESS: begin
					long_limit = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Advance every button by one tick and queue the resulting events.
		function void take_tick(logic [bcl_pkg::LEVEL_W-1:0] levels);
			tick_events_t due;
			due = '0;
			for (int b = 0; b < bcl_pkg::LEVEL_W; b++) begin
				if (!levels[b]) begin
					if (!flagged[b]) begin
						if (hold_ticks[b] != '1)
							hold_ticks[b]++;
						seen[b] = 1'b1;
						if (down[b]) begin
							if (hold_ticks[b] >= long_limit) begin
								flagged[b] = 1'b1;
								due.longs[b] = 1'b1;
							end
						end else if (hold_ticks[b] >= debounce_limit) begin
							down[b] = 1'b1;
						end
					end
				end else if (seen[b]) begin
					if (down[b] && !flagged[b])
						due.clicks[b] = 1'b1;
					seen[b] = 1'b0;
					down[b] = 1'b0;
					flagged[b] = 1'b0;
					hold_ticks[b] = '0;
				end
			end
			due_events.push_back(due);
		endfunction

		function void check_events(logic [bcl_pkg::EVENT_W-1:0] clicks,
			logic [bcl_pkg::EVENT_W-1:0] longs);
			tick_events_t want;
			if (due_events.size() == 0) begin
				$error("events result with no tick pending: click_events %h long_events %h",
					clicks, longs);
				failures++;
				return;
			end
			want = due_events.pop_front();
			if (want.clicks !== clicks) begin
				$error("click_events mismatch: expected %h, actual %h", want.clicks, clicks);
				failures++;
			end
			if (want.longs !== longs) begin
				$error("long_events mismatch: expected %h, actual %h", want.longs, longs);
				failures++;
			end
		endfunction

		function int outstanding();
			return due_events.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bcl_in_if  samples_ch();
	bcl_out_if events_ch();
	bcl_cfg_if cfg_ch();

	button_click_long_press_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.events (events_ch),
		.cfg    (cfg_ch)
	);

	press_scoreboard sb;

	// Idle switches: each side flips its own now and then, so stretches
	// with and without gaps alternate.
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one tick request after a random gap and hold it until taken.
	// Called and returns at a falling edge; valid is only dropped when a gap
	// follows, so back-to-back requests keep it high.
	task automatic send_tick(input logic [bcl_pkg::LEVEL_W-1:0] lv);
		int gap;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if ($urandom_range(0, 39) == 0)
			send_idle = !send_idle;
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.button_levels <= lv;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		sb.take_tick(lv);
		@(negedge clk);
	endtask

	// Write one register; leave valid high so writes can go back to back.
	task automatic write_reg(input logic [bcl_pkg::CFG_IDX_W-1:0] idx,
		input logic [bcl_pkg::CFG_DAT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [bcl_pkg::CNT_W-1:0] deb,
		input logic [bcl_pkg::CNT_W-1:0] lng);
		write_reg(bcl_pkg::REG_DEBOUNCE, deb);
		write_reg(bcl_pkg::REG_LONG_PRESS, lng);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop sending and wait until every pending tick has its result, then
	// let the output register empty.
	task automatic settle();
		samples_ch.valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Press and release every button in runs sized around the current
	// limits: mostly real presses (short, debounced, long), some bounces,
	// and now and then a tick of random noise on all pins.
	task automatic run_random(input int count);
		int run_left[bcl_pkg::LEVEL_W];
		bit held[bcl_pkg::LEVEL_W];
		int pick;
		int noise;
		logic [bcl_pkg::LEVEL_W-1:0] lv;
		foreach (run_left[b]) begin
			run_left[b] = 0;
			held[b] = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			for (int b = 0; b < bcl_pkg::LEVEL_W; b++) begin
				if (run_left[b] == 0) begin
					held[b] = !held[b];
					pick = $urandom_range(0, 9);
					if (!held[b])
						run_left[b] = $urandom_range(1, 4);
					else if (pick < 2)
						run_left[b] = $urandom_range(1, 2);
					else if (pick < 5)
						run_left[b] = $urandom_range(1, sb.debounce_limit + 2);
					else
						run_left[b] = $urandom_range(sb.debounce_limit + 1,
							sb.debounce_limit + sb.long_limit + 3);
				end
				lv[b] = !held[b];
				run_left[b]--;
			end
			if ($urandom_range(0, 11) == 0) begin
				noise = $urandom_range(0, 15);
				lv = noise[bcl_pkg::LEVEL_W-1:0];
			end
			send_tick(lv);
		end
	endtask

	// Result side: stall ready for a random number of cycles per result,
	// then check whatever is taken against the oldest expectation.
	initial begin
		int stall;
		events_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 6) : 0;
			if ($urandom_range(0, 29) == 0)
				recv_idle = !recv_idle;
			if (stall > 0) begin
				events_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			events_ch.ready <= 1'b1;
			@(posedge clk);
			while (!events_ch.valid)
				@(posedge clk);
			sb.check_events(events_ch.click_events, events_ch.long_events);
			@(negedge clk);
		end
	end

	initial begin
		logic [bcl_pkg::LEVEL_W-1:0] zero_plan[$];
		logic [bcl_pkg::LEVEL_W-1:0] skew_plan[$];
		int deb_pick;
		int lng_pick;
		sb = new();
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.button_levels = '1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Zero limits: first held tick marks down, second gives the long
		// event. Writes to unused indexes go first and must change nothing.
		write_reg(REG_SPARE, 16'h0005);
		write_reg(REG_TOP, 16'hFFFF);
		set_limits(16'd0, 16'd0);
		// all released with nothing detected; hold all into a long press;
		// one-tick press that clicks; back-to-back presses on alternate pins
		zero_plan = '{4'hF, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'hF, 4'h5, 4'hA, 4'hF};
		foreach (zero_plan[i])
			send_tick(zero_plan[i]);
		settle();

		// Long limit below debounce: the long event lands one tick after
		// the down mark. Then a press too short to count, and a plain click.
		set_limits(16'd3, 16'd1);
		skew_plan = '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0, 4'hF,
			4'hC, 4'hC, 4'hC, 4'hF, 4'hF};
		foreach (skew_plan[i])
			send_tick(skew_plan[i]);
		settle();

		// Back to the power-on limits for a long random stretch
		set_limits(bcl_pkg::DEBOUNCE_RESET, bcl_pkg::LONG_PRESS_RESET);
		run_random(400);

		// Small random limits, zero included, where events come often
		for (int p = 0; p < 5; p++) begin
			settle();
			deb_pick = $urandom_range(0, 6);
			lng_pick = $urandom_range(0, 15);
			set_limits(deb_pick[bcl_pkg::CNT_W-1:0], lng_pick[bcl_pkg::CNT_W-1:0]);
			run_random(70);
		end

		// Drain what is left, with a bound
		samples_ch.valid <= 1'b0;
		for (int w = 0; w < 2000 && sb.outstanding() > 0; w++)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (sb.outstanding() > 0) begin
			$error("%0d expected events results never arrived", sb.outstanding());
			sb.failures++;
		end

		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
src/bcl_pkg.sv
src/bcl_in_if.sv
src/bcl_out_if.sv
src/bcl_cfg_if.sv
src/bcl_button.sv
src/button_click_long_press_top.sv
bench/testbench.sv
